// ===== hdl/twes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// twes_pkg: shared constants for the three-way entropy select pipeline
// Default widths and the fixed sizes of the log2 squaring datapath.
// ----------------------------------------------------------------------------
package twes_pkg;

   // Default fraction bits of the probability and entropy fields.
   localparam int FRAC_BITS_DEFAULT  = 16;
   // Default coordinate width.
   localparam int COORD_BITS_DEFAULT = 16;

   // Fraction bits produced by the log2 unit, one per squaring stage.
   localparam int LOG_FRAC  = 32;
   // Normalized mantissa width (Q1.30).
   localparam int MANT_BITS = 31;
   // Number of probabilities per node.
   localparam int LANES     = 3;

endpackage : twes_pkg
`default_nettype wire

// ===== hdl/three_way_entropy_select.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// three_way_entropy_select: pipelined Shannon entropy and threshold select
//
// A node arrives on the req_ channel as x/y coordinates and three Q1.16
// probabilities (values above 1.0 saturate to 1.0). The block returns one
// transfer per node on the rsp_ channel: the entropy -sum(p*log2 p) in
// Q1.16, rounded to nearest, the coordinates, and a flag that is set when
// the entropy is at or above the threshold register.
// The threshold is written through the csr_ channel, which is always ready;
// write it only while no node is in flight.
// A node passes 37 register stages: one normalize stage, 32 squaring stages
// of the log2 unit (one fraction bit each), a product stage, a term stage,
// a sum stage and the output register. Its result is presented on
// rsp_valid. One node is accepted every cycle while req_ready is high.
// When the receiver stalls, the output register holds its result; the
// pipeline behind it keeps moving as long as the sum stage is empty, and
// req_ready drops only once the sum stage holds a node as well.
// Reset clears all valid bits and sets the threshold to 1.0.
// ----------------------------------------------------------------------------
module three_way_entropy_select #(
   parameter int FRAC_BITS  = twes_pkg::FRAC_BITS_DEFAULT,
   parameter int COORD_BITS = twes_pkg::COORD_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   // Node input channel.
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire signed [COORD_BITS-1:0]   req_x_coord,
   input  wire signed [COORD_BITS-1:0]   req_y_coord,
   input  wire        [FRAC_BITS:0]      req_p_assign,
   input  wire        [FRAC_BITS:0]      req_p_route,
   input  wire        [FRAC_BITS:0]      req_p_loss,
   // Result channel.
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic       [FRAC_BITS:0]      rsp_entropy,
   output logic                          rsp_selected,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   // Threshold register write channel.
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire        [FRAC_BITS+1:0]    csr_entropy_threshold
);

   localparam int LF     = twes_pkg::LOG_FRAC;
   localparam int MW     = twes_pkg::MANT_BITS;
   localparam int NL     = twes_pkg::LANES;
   localparam int P_W    = FRAC_BITS + 1;
   localparam int THR_W  = FRAC_BITS + 2;
   // Holds the exponent and FRAC_BITS minus the exponent.
   localparam int E_W    = $clog2(FRAC_BITS + 1);
   localparam int SH_W   = $clog2(MW);
   localparam int PF_W   = P_W + LF;
   localparam int PE_W   = P_W + E_W;
   localparam int TERM_W = PE_W + LF;
   localparam int SUM_W  = TERM_W + 2;
   localparam int ENT_W  = SUM_W - LF;

   localparam logic [P_W-1:0]   ONE_P   = P_W'(1) << FRAC_BITS;
   localparam logic [THR_W-1:0] THR_RST = THR_W'(1) << FRAC_BITS;

   // ------------------------------------------------------------------------
   // Flow control. Every stage up to the sum stage moves together; the only
   // holdup is a full sum stage behind a stalled output register.
   // ------------------------------------------------------------------------
   logic adv;
   logic out_load;
   logic sm_v_ff;
   logic rsp_valid_ff;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign adv       = out_load || !sm_v_ff;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------------
   // Threshold register.
   // ------------------------------------------------------------------------
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RST;
      end else if (csr_valid) begin
         thr_ff <= csr_entropy_threshold;
      end
   end

   // ------------------------------------------------------------------------
   // Squaring pipeline storage. Index 0 is the normalize stage; index k holds
   // the item after k squaring steps.
   // ------------------------------------------------------------------------
   logic [MW-1:0]               sq_m_ff [0:LF-1][0:NL-1];
   logic [LF-1:0]               sq_f_ff [0:LF][0:NL-1];
   logic [P_W-1:0]              sq_p_ff [0:LF][0:NL-1];
   logic [E_W-1:0]              sq_d_ff [0:LF][0:NL-1];
   logic                        sq_z_ff [0:LF][0:NL-1];
   logic signed [COORD_BITS-1:0] sq_x_ff [0:LF];
   logic signed [COORD_BITS-1:0] sq_y_ff [0:LF];
   logic                        sq_v_ff [0:LF];

   // ------------------------------------------------------------------------
   // Normalize stage: saturate, flag zero, find the leading one and shift
   // the probability into a Q1.30 mantissa.
   // ------------------------------------------------------------------------
   logic [P_W-1:0] p_raw [0:NL-1];
   logic [P_W-1:0] p_sat_in [0:NL-1];
   logic [E_W-1:0] e_in [0:NL-1];
   logic [MW-1:0]  m_in [0:NL-1];

   always_comb begin
      p_raw[0] = req_p_assign;
      p_raw[1] = req_p_route;
      p_raw[2] = req_p_loss;
      for (int l = 0; l < NL; l++) begin
         p_sat_in[l] = (p_raw[l] > ONE_P) ? ONE_P : p_raw[l];
         e_in[l] = '0;
         for (int i = 0; i < P_W; i++) begin
            if (p_sat_in[l][i]) begin
               e_in[l] = E_W'(i);
            end
         end
         m_in[l] = MW'(MW'(p_sat_in[l]) << (SH_W'(MW - 1) - SH_W'(e_in[l])));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) begin
            sq_m_ff[0][l] <= m_in[l];
            sq_f_ff[0][l] <= '0;
            sq_p_ff[0][l] <= p_sat_in[l];
            sq_d_ff[0][l] <= E_W'(FRAC_BITS) - e_in[l];
            sq_z_ff[0][l] <= (p_raw[l] == '0);
         end
         sq_x_ff[0] <= req_x_coord;
         sq_y_ff[0] <= req_y_coord;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= req_valid;
      end
   end

   // ------------------------------------------------------------------------
   // Squaring stages: each squares the mantissa, takes one fraction bit of
   // the logarithm from the overflow, and renormalizes (all but the last stage).
   // ------------------------------------------------------------------------
   for (genvar k = 1; k <= LF; k++) begin : g_sq
      for (genvar l = 0; l < NL; l++) begin : g_lane
         logic [2*MW-1:0] sq_full;
         logic [MW:0]     sq_top;

         assign sq_full = (2*MW)'(sq_m_ff[k-1][l]) * (2*MW)'(sq_m_ff[k-1][l]);
         assign sq_top  = sq_full[2*MW-1:MW-1];

         if (k < LF) begin : g_mant
            always_ff @(posedge clock) begin
               if (adv) begin
                  sq_m_ff[k][l] <= sq_top[MW] ? sq_top[MW:1] : sq_top[MW-1:0];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               sq_f_ff[k][l] <= {sq_f_ff[k-1][l][LF-2:0], sq_top[MW]};
               sq_p_ff[k][l] <= sq_p_ff[k-1][l];
               sq_d_ff[k][l] <= sq_d_ff[k-1][l];
               sq_z_ff[k][l] <= sq_z_ff[k-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_x_ff[k] <= sq_x_ff[k-1];
            sq_y_ff[k] <= sq_y_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Product stage: p times the fraction of log2 p, and p times the negated
   // integer part of log2 p.
   // ------------------------------------------------------------------------
   logic [PF_W-1:0]             pr_f_ff [0:NL-1];
   logic [PE_W-1:0]             pr_e_ff [0:NL-1];
   logic                        pr_z_ff [0:NL-1];
   logic signed [COORD_BITS-1:0] pr_x_ff;
   logic signed [COORD_BITS-1:0] pr_y_ff;
   logic                        pr_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) begin
            pr_f_ff[l] <= PF_W'(sq_p_ff[LF][l]) * PF_W'(sq_f_ff[LF][l]);
            pr_e_ff[l] <= PE_W'(sq_p_ff[LF][l]) * PE_W'(sq_d_ff[LF][l]);
            pr_z_ff[l] <= sq_z_ff[LF][l];
         end
         pr_x_ff <= sq_x_ff[LF];
         pr_y_ff <= sq_y_ff[LF];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else if (adv) begin
         pr_v_ff <= sq_v_ff[LF];
      end
   end

   // ------------------------------------------------------------------------
   // Term stage: p * (-log2 p) exact at 2^-(FRAC_BITS+32); zero terms drop.
   // ------------------------------------------------------------------------
   logic [TERM_W-1:0]           tm_ff [0:NL-1];
   logic signed [COORD_BITS-1:0] tm_x_ff;
   logic signed [COORD_BITS-1:0] tm_y_ff;
   logic                        tm_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NL; l++) begin
            tm_ff[l] <= pr_z_ff[l] ? '0
                      : ({pr_e_ff[l], {LF{1'b0}}} - TERM_W'(pr_f_ff[l]));
         end
         tm_x_ff <= pr_x_ff;
         tm_y_ff <= pr_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tm_v_ff <= 1'b0;
      end else if (adv) begin
         tm_v_ff <= pr_v_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Sum stage: add the three terms and the rounding half.
   // ------------------------------------------------------------------------
   logic [SUM_W-1:0]            sm_ff;
   logic signed [COORD_BITS-1:0] sm_x_ff;
   logic signed [COORD_BITS-1:0] sm_y_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_ff <= SUM_W'(tm_ff[0]) + SUM_W'(tm_ff[1]) + SUM_W'(tm_ff[2])
                + (SUM_W'(1) << (LF - 1));
         sm_x_ff <= tm_x_ff;
         sm_y_ff <= tm_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_v_ff <= 1'b0;
      end else if (adv) begin
         sm_v_ff <= tm_v_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Output register: drop the rounded fraction, clamp to the field, compare.
   // ------------------------------------------------------------------------
   logic [ENT_W-1:0] ent_full;
   logic [P_W-1:0]   ent_in;

   assign ent_full = sm_ff[SUM_W-1:LF];
   assign ent_in   = (|ent_full[ENT_W-1:P_W]) ? '1 : ent_full[P_W-1:0];

   logic [P_W-1:0]              ent_ff;
   logic                        sel_ff;
   logic signed [COORD_BITS-1:0] out_x_ff;
   logic signed [COORD_BITS-1:0] out_y_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         ent_ff   <= ent_in;
         sel_ff   <= ({1'b0, ent_in} >= thr_ff);
         out_x_ff <= sm_x_ff;
         out_y_ff <= sm_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= sm_v_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_entropy  = ent_ff;
   assign rsp_selected = sel_ff;
   assign rsp_out_x    = out_x_ff;
   assign rsp_out_y    = out_y_ff;

endmodule : three_way_entropy_select
`default_nettype wire
